/* design/positional_list_insert_delete_assert.svh */
// Assertion macros for the positional list block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define PLID_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define PLID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/plid_pkg.sv */
// Types and constants shared by the positional list block.
package plid_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned CNT_OUT_W = 5;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned S_DATA_W  = 40;
	localparam int unsigned M_DATA_W  = 40;

	localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] REQ_READ   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INS_WR,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

/* design/positional_list_insert_delete.sv */
// Positional list: ordered word store with insert, delete and read at a position.
// One request at a time; s_tready is high only while the sequencer is idle.
// A read passes ST_READ, then ST_DONE; a refused or unknown request goes straight to ST_DONE.
// Insert shifts entries up from the position, then writes the value; delete shifts those above it down.
// Each moved entry takes a read and a write state; s_tready returns as m_tvalid rises.
// Reset (arst_n low) empties the list and drops m_tvalid; store contents are not cleared.
`include "positional_list_insert_delete_assert.svh"

module positional_list_insert_delete #(
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [plid_pkg::S_DATA_W-1:0]  s_tdata,  // position[4:0], value[36:5], zero pad
	input  logic [plid_pkg::KIND_W-1:0]    s_tuser,  // req_type[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [plid_pkg::M_DATA_W-1:0]  m_tdata,  // read_value[31:0], count[36:32], zero pad
	output logic [0:0]                     m_tuser   // ok[0]
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W;

	plid_pkg::state_t state_q, state_d;

	logic [plid_pkg::WORD_W-1:0] mem [DEPTH];
	logic [plid_pkg::WORD_W-1:0] rd_data_q;

	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 idx_q;
	logic [CW-1:0]                 pos_q;
	logic [plid_pkg::KIND_W-1:0]   kind_q;
	logic [plid_pkg::WORD_W-1:0]   value_q;
	logic                          ok_q;

	logic                          m_tvalid_q;
	logic                          m_ok_q;
	logic [plid_pkg::WORD_W-1:0]   m_rd_q;
	logic [plid_pkg::CNT_OUT_W-1:0] m_cnt_q;

	logic                          s_xfer;
	logic [plid_pkg::KIND_W-1:0]   kind_in;
	logic [CMPW-1:0]               pos_ext;
	logic [CMPW-1:0]               cnt_ext;
	logic                          ins_ok, del_ok, rd_ok, req_ok;
	logic [CW-1:0]                 step_idx;
	logic                          mem_we, mem_re;
	logic [AW-1:0]                 mem_waddr, mem_raddr;
	logic [plid_pkg::WORD_W-1:0]   mem_wdata;
	logic                          out_ld;
	logic [CW-1:0]                 cnt_new;
	logic [CMPW-1:0]               cnt_new_ext;

	assign s_tready = (state_q == plid_pkg::ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign kind_in  = s_tuser;
	assign pos_ext  = CMPW'(s_tdata[plid_pkg::POS_W-1:0]);
	assign cnt_ext  = CMPW'(cnt_q);

	// range checks on the incoming request
	assign ins_ok = (pos_ext <= cnt_ext) && (cnt_ext < CMPW'(DEPTH));
	assign del_ok = (pos_ext < cnt_ext);
	assign rd_ok  = (pos_ext < cnt_ext);

	always_comb begin
		case (kind_in)
			plid_pkg::REQ_INSERT: req_ok = ins_ok;
			plid_pkg::REQ_DELETE: req_ok = del_ok;
			plid_pkg::REQ_READ:   req_ok = rd_ok;
			default:              req_ok = 1'b0;
		endcase
	end

	// shared cursor step: down for insert, up for delete
	assign step_idx = (kind_q == plid_pkg::REQ_INSERT) ? (idx_q - CW'(1)) : (idx_q + CW'(1));

	assign out_ld = (state_q == plid_pkg::ST_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		case (kind_q)
			plid_pkg::REQ_INSERT: cnt_new = ok_q ? (cnt_q + CW'(1)) : cnt_q;
			plid_pkg::REQ_DELETE: cnt_new = ok_q ? (cnt_q - CW'(1)) : cnt_q;
			default:              cnt_new = cnt_q;
		endcase
	end
	assign cnt_new_ext = CMPW'(cnt_new);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plid_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_raddr = step_idx[AW-1:0];
		mem_wdata = rd_data_q;
		unique case (state_q)
			plid_pkg::ST_IDLE: begin
				if (s_xfer) begin
					if (!req_ok) begin
						state_d = plid_pkg::ST_DONE;
					end else begin
						case (kind_in)
							plid_pkg::REQ_INSERT: begin
								state_d = (pos_ext == cnt_ext) ? plid_pkg::ST_INS_WR
									: plid_pkg::ST_SHIFT_RD;
							end
							plid_pkg::REQ_DELETE: begin
								state_d = ((pos_ext + CMPW'(1)) < cnt_ext)
									? plid_pkg::ST_SHIFT_RD : plid_pkg::ST_DONE;
							end
							default: state_d = plid_pkg::ST_READ;
						endcase
					end
				end
			end
			plid_pkg::ST_SHIFT_RD: begin
				mem_re  = 1'b1;
				state_d = plid_pkg::ST_SHIFT_WR;
			end
			plid_pkg::ST_SHIFT_WR: begin
				mem_we = 1'b1;
				if (kind_q == plid_pkg::REQ_INSERT) begin
					state_d = (step_idx == pos_q) ? plid_pkg::ST_INS_WR
						: plid_pkg::ST_SHIFT_RD;
				end else begin
					state_d = ((step_idx + CW'(1)) < cnt_q) ? plid_pkg::ST_SHIFT_RD
						: plid_pkg::ST_DONE;
				end
			end
			plid_pkg::ST_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = value_q;
				state_d   = plid_pkg::ST_DONE;
			end
			plid_pkg::ST_READ: begin
				mem_re    = 1'b1;
				mem_raddr = pos_q[AW-1:0];
				state_d   = plid_pkg::ST_DONE;
			end
			plid_pkg::ST_DONE: begin
				if (out_ld) begin
					state_d = plid_pkg::ST_IDLE;
				end
			end
			default: state_d = plid_pkg::ST_IDLE;
		endcase
	end

	// list store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// request context and cursor
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			kind_q  <= kind_in;
			pos_q   <= pos_ext[CW-1:0];
			value_q <= s_tdata[plid_pkg::POS_W +: plid_pkg::WORD_W];
			ok_q    <= req_ok;
			idx_q   <= (kind_in == plid_pkg::REQ_INSERT) ? cnt_q : pos_ext[CW-1:0];
		end else if (state_q == plid_pkg::ST_SHIFT_WR) begin
			idx_q <= step_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (out_ld) begin
			cnt_q <= cnt_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			m_ok_q  <= ok_q;
			m_rd_q  <= (ok_q && (kind_q == plid_pkg::REQ_READ)) ? rd_data_q : '0;
			m_cnt_q <= cnt_new_ext[plid_pkg::CNT_OUT_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_ok_q;
	assign m_tdata  = {3'b000, m_cnt_q, m_rd_q};

	`PLID_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(DEPTH), "entry count above depth")
	`PLID_ASSERT_NEXT(a_cnt_hold, state_q != plid_pkg::ST_DONE, $stable(cnt_q),
		"count moved outside done")
	`PLID_ASSERT_NEXT(a_busy_after_xfer, s_xfer, !s_tready, "ready held after input transfer")
	`PLID_ASSERT_ALWAYS(a_shift_idx,
		(state_q != plid_pkg::ST_SHIFT_WR) || (idx_q < CW'(DEPTH)), "shift cursor out of range")

endmodule

/* sim/positional_list_insert_delete_test.sv */
// Testbench for the positional list: directed and random list requests checked against a list model.
module positional_list_insert_delete_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam logic [plid_pkg::KIND_W-1:0] REQ_UNKNOWN = 2'd3;
	localparam int RANDOM_ITEMS = 380;
	localparam int CALM_ITEMS = 60;

	typedef struct {
		logic                           ok;
		logic [plid_pkg::WORD_W-1:0]    word;
		logic [plid_pkg::CNT_OUT_W-1:0] count;
	} list_answer_t;

	class list_scoreboard;
		logic [plid_pkg::WORD_W-1:0] entries [DEPTH];
		int unsigned       fill;
		list_answer_t      answers [$];
		int unsigned       mismatches;
		int unsigned       done_ins, done_del, done_rd, refused, peak;

		function new();
			fill = 0;
			mismatches = 0;
			done_ins = 0;
			done_del = 0;
			done_rd = 0;
			refused = 0;
			peak = 0;
		endfunction

		function int unsigned pending();
			return answers.size();
		endfunction

		// apply one accepted request to the list copy and queue its answer
		function void note_request(logic [plid_pkg::KIND_W-1:0] kind,
				logic [plid_pkg::POS_W-1:0] position, logic [plid_pkg::WORD_W-1:0] word);
			list_answer_t a;
			int unsigned  i;
			a.ok = 1'b0;
			a.word = '0;
			case (kind)
				plid_pkg::REQ_INSERT: begin
					if (position <= fill && fill < DEPTH) begin
						for (i = fill; i > position; i--)
							entries[i] = entries[i - 1];
						entries[position] = word;
						fill++;
						a.ok = 1'b1;
						done_ins++;
					end
				end
				plid_pkg::REQ_DELETE: begin
					if (position < fill) begin
						for (i = position; i + 1 < fill; i++)
							entries[i] = entries[i + 1];
						fill--;
						a.ok = 1'b1;
						done_del++;
					end
				end
				plid_pkg::REQ_READ: begin
					if (position < fill) begin
						a.word = entries[position];
						a.ok = 1'b1;
						done_rd++;
					end
				end
				default: ;
			endcase
			if (!a.ok)
				refused++;
			if (fill > peak)
				peak = fill;
			a.count = fill[plid_pkg::CNT_OUT_W-1:0];
			answers.push_back(a);
		endfunction

		function void check_result(logic ok, logic [plid_pkg::WORD_W-1:0] word,
				logic [plid_pkg::CNT_OUT_W-1:0] count);
			list_answer_t a;
			if (answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request pending: ok=%0b value=%h count=%0d",
						$realtime, ok, word, count);
				return;
			end
			a = answers.pop_front();
			if (ok !== a.ok || word !== a.word || count !== a.count) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: mismatch: expected ok=%0b value=%h count=%0d, ",
						"got ok=%0b value=%h count=%0d"},
						$realtime, a.ok, a.word, a.count, ok, word, count);
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [plid_pkg::S_DATA_W-1:0]  s_tdata;
	logic [plid_pkg::KIND_W-1:0]    s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [plid_pkg::M_DATA_W-1:0]  m_tdata;
	logic [0:0]                     m_tuser;

	list_scoreboard sb = new();
	bit             calm = 1'b0;
	int unsigned    stall_left = 0;

	positional_list_insert_delete #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: stalls in bursts, none once the run turns calm
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_left <= 0;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 8) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser[0], m_tdata[31:0], m_tdata[36:32]);
	end

	task automatic send_request(input logic [plid_pkg::KIND_W-1:0] kind, input int position,
			input logic [plid_pkg::WORD_W-1:0] word);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {3'b000, word, position[plid_pkg::POS_W-1:0]};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(kind, position[plid_pkg::POS_W-1:0], word);
	endtask

	task automatic sender_gap(input int item);
		// every third stretch of 32 transfers runs back to back
		if (!calm && (item / 32) % 3 != 2 && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	function automatic logic [plid_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [plid_pkg::KIND_W-1:0] kind;
		int                position;
		int                r;
		int                p_ins;
		int                p_del;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= plid_pkg::REQ_INSERT;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: everything but an insert at the head is refused
		send_request(plid_pkg::REQ_READ, 0, 32'h1234_5678);
		send_request(plid_pkg::REQ_DELETE, 0, '0);
		send_request(plid_pkg::REQ_INSERT, 1, 32'hDEAD_BEEF);
		send_request(REQ_UNKNOWN, 0, 32'h5555_AAAA);
		send_request(plid_pkg::REQ_INSERT, 0, 32'h8000_0000);
		send_request(plid_pkg::REQ_INSERT, 1, 32'h7FFF_FFFF);
		send_request(plid_pkg::REQ_INSERT, 1, 32'h0000_0000);
		send_request(plid_pkg::REQ_READ, 0, '0);
		// fill up, alternating head, tail and middle
		for (int k = 0; k < 13; k++) begin
			case (k % 3)
				0: position = 0;
				1: position = sb.fill;
				default: position = sb.fill / 2;
			endcase
			send_request(plid_pkg::REQ_INSERT, position, $urandom);
		end
		send_request(plid_pkg::REQ_INSERT, 0, 32'hFFFF_FFFF);
		send_request(plid_pkg::REQ_READ, DEPTH - 1, '0);
		send_request(plid_pkg::REQ_READ, DEPTH, '0);
		send_request(plid_pkg::REQ_READ, 31, 32'hFFFF_FFFF);
		send_request(plid_pkg::REQ_DELETE, DEPTH - 1, '0);
		send_request(plid_pkg::REQ_DELETE, 0, '0);
		send_request(plid_pkg::REQ_DELETE, 7, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			sender_gap(n);
			// alternate growing and shrinking phases so both full and empty are hit
			if ((n / 50) % 2 == 0) begin
				p_ins = 55;
				p_del = 15;
			end else begin
				p_ins = 20;
				p_del = 50;
			end
			r = $urandom_range(0, 99);
			if (r < 3)
				kind = REQ_UNKNOWN;
			else if (r < 3 + p_ins)
				kind = plid_pkg::REQ_INSERT;
			else if (r < 3 + p_ins + p_del)
				kind = plid_pkg::REQ_DELETE;
			else
				kind = plid_pkg::REQ_READ;
			if ($urandom_range(0, 9) < 8) begin
				if (kind == plid_pkg::REQ_INSERT)
					position = $urandom_range(0, sb.fill);
				else
					position = (sb.fill == 0) ? 0 : $urandom_range(0, sb.fill - 1);
			end else begin
				position = $urandom_range(0, 31);
			end
			send_request(kind, position, pick_word());
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);

		$display("Requests done: %0d inserts, %0d deletes, %0d reads; %0d refused.",
			sb.done_ins, sb.done_del, sb.done_rd, sb.refused);
		$display("Peak fill %0d of %0d entries, %0d mismatches.", sb.peak, DEPTH,
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d results outstanding", sb.pending());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
